// ===== hw/rtl/hcc_pkg.sv =====
package hcc_pkg;

    localparam int unsigned WORD_W = 16;
    localparam int unsigned ADDR_W = 15;

    localparam logic [WORD_W-1:0] ALL_ONES = 16'hFFFF;

    typedef enum logic [5:0] {
        COMP_D_AND_Y   = 6'h00,
        COMP_D_PLUS_Y  = 6'h02,
        COMP_Y_MINUS_D = 6'h07,
        COMP_D         = 6'h0C,
        COMP_NOT_D     = 6'h0D,
        COMP_D_MINUS_1 = 6'h0E,
        COMP_NEG_D     = 6'h0F,
        COMP_D_MINUS_Y = 6'h13,
        COMP_D_OR_Y    = 6'h15,
        COMP_D_PLUS_1  = 6'h1F,
        COMP_ZERO      = 6'h2A,
        COMP_Y         = 6'h30,
        COMP_NOT_Y     = 6'h31,
        COMP_Y_MINUS_1 = 6'h32,
        COMP_NEG_Y     = 6'h33,
        COMP_Y_PLUS_1  = 6'h37,
        COMP_ONES      = 6'h3A,
        COMP_ONE       = 6'h3F
    } comp_t;

    typedef enum logic [2:0] {
        JMP_NEVER = 3'd0,
        JMP_GT    = 3'd1,
        JMP_EQ    = 3'd2,
        JMP_GE    = 3'd3,
        JMP_LT    = 3'd4,
        JMP_NE    = 3'd5,
        JMP_LE    = 3'd6,
        JMP_ALWAYS = 3'd7
    } jump_t;

    typedef struct packed {
        logic [ADDR_W-1:0]        next_pc;
        logic signed [WORD_W-1:0] a_value;
        logic signed [WORD_W-1:0] d_value;
        logic                     mem_write;
        logic [ADDR_W-1:0]        mem_address;
        logic signed [WORD_W-1:0] mem_data;
        logic                     halted;
        logic                     bad_op;
    } result_t;

endpackage

// ===== hw/rtl/hcc_ram.sv =====
module hcc_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/hcc_exec.sv =====
module hcc_exec
    import hcc_pkg::*;
(
    input  logic [WORD_W-1:0] instruction,
    input  logic [WORD_W-1:0] a_cur,
    input  logic [WORD_W-1:0] d_cur,
    input  logic [WORD_W-1:0] m_cur,
    input  logic [ADDR_W-1:0] pc_cur,
    input  logic [WORD_W-1:0] program_length,
    output result_t           res
);

    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] r;
    logic              comp_ok;
    logic              neg;
    logic              zero;
    logic              pos;
    logic              take;
    logic [ADDR_W-1:0] pc_inc;

    assign y      = instruction[12] ? m_cur : a_cur;
    assign pc_inc = pc_cur + ADDR_W'(1);

    always_comb begin
        comp_ok = 1'b1;
        r       = '0;
        unique case (instruction[11:6])
            COMP_D_AND_Y:   r = d_cur & y;
            COMP_D_PLUS_Y:  r = d_cur + y;
            COMP_Y_MINUS_D: r = y - d_cur;
            COMP_D:         r = d_cur;
            COMP_NOT_D:     r = d_cur ^ ALL_ONES;
            COMP_D_MINUS_1: r = d_cur - WORD_W'(1);
            COMP_NEG_D:     r = WORD_W'(0) - d_cur;
            COMP_D_MINUS_Y: r = d_cur - y;
            COMP_D_OR_Y:    r = d_cur | y;
            COMP_D_PLUS_1:  r = d_cur + WORD_W'(1);
            COMP_ZERO:      r = '0;
            COMP_Y:         r = y;
            COMP_NOT_Y:     r = y ^ ALL_ONES;
            COMP_Y_MINUS_1: r = y - WORD_W'(1);
            COMP_NEG_Y:     r = WORD_W'(0) - y;
            COMP_Y_PLUS_1:  r = y + WORD_W'(1);
            COMP_ONES:      r = ALL_ONES;
            COMP_ONE:       r = WORD_W'(1);
            default:        comp_ok = 1'b0;
        endcase
    end

    assign neg  = r[WORD_W-1];
    assign zero = (r == '0);
    assign pos  = !neg && !zero;

    always_comb begin
        unique case (jump_t'(instruction[2:0]))
            JMP_NEVER:  take = 1'b0;
            JMP_GT:     take = pos;
            JMP_EQ:     take = zero;
            JMP_GE:     take = !neg;
            JMP_LT:     take = neg;
            JMP_NE:     take = !zero;
            JMP_LE:     take = !pos;
            JMP_ALWAYS: take = 1'b1;
            default:    take = 1'b0;
        endcase
    end

    always_comb begin
        res             = '0;
        res.next_pc     = pc_inc;
        res.a_value     = a_cur;
        res.d_value     = d_cur;
        if (!instruction[15]) begin
            res.a_value = instruction;
        end else begin
            res.mem_address = a_cur[ADDR_W-1:0];
            if (!comp_ok) begin
                res.bad_op = 1'b1;
            end else begin
                if (instruction[5]) begin
                    res.a_value = r;
                end
                if (instruction[4]) begin
                    res.d_value = r;
                end
                if (instruction[3]) begin
                    res.mem_write = 1'b1;
                    res.mem_data  = r;
                end
                if (take) begin
                    res.next_pc = a_cur[ADDR_W-1:0];
                end
            end
        end
        res.halted = ({1'b0, res.next_pc} >= program_length);
    end

endmodule

// ===== hw/rtl/hcc_out_skid.sv =====
module hcc_out_skid
    import hcc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    result_t out_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
                out_data_reg  <= in_data;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
            skid_data_reg  <= in_data;
        end
    end

endmodule

// ===== hw/rtl/hack_cpu_core.sv =====
// Results are registered in the output skid buffer as instructions are accepted.
// Throughput: one instruction per cycle while s_ready is high; the M operand is read
// ahead from data RAM at the next instruction's A value, with write forwarding.
// Reset: A, D, PC and program_length clear; then all DATA_DEPTH data RAM words are
// zeroed one per cycle, s_ready low meanwhile (cfg writes still taken).
module hack_cpu_core
    import hcc_pkg::*;
#(
    parameter int unsigned DATA_DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [15:0]              cfg_program_length,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [15:0]              s_instruction,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [14:0]              m_next_pc,
    output logic signed [15:0]       m_a_value,
    output logic signed [15:0]       m_d_value,
    output logic                     m_mem_write,
    output logic [14:0]              m_mem_address,
    output logic signed [15:0]       m_mem_data,
    output logic                     m_halted,
    output logic                     m_bad_op
);

    localparam int unsigned AW = $clog2(DATA_DEPTH);

    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] d_reg;
    logic [ADDR_W-1:0] pc_reg;
    logic [WORD_W-1:0] prog_len_reg;
    logic              clearing_reg;
    logic [AW-1:0]     clr_cnt_reg;
    logic              rd_in_range_reg;
    logic              fwd_hit_reg;
    logic [WORD_W-1:0] fwd_data_reg;

    logic              skid_ready;
    logic              accept;
    result_t           res;
    result_t           out_res;
    logic [WORD_W-1:0] a_next;
    logic [WORD_W-1:0] m_operand;
    logic [WORD_W-1:0] ram_rdata;
    logic [AW-1:0]     raddr;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [WORD_W-1:0] wdata;
    logic              wr_in_range;

    assign cfg_ready = 1'b1;
    assign s_ready   = !clearing_reg && skid_ready;
    assign accept    = s_valid && s_ready;

    assign m_operand = !rd_in_range_reg ? '0 : (fwd_hit_reg ? fwd_data_reg : ram_rdata);

    hcc_exec u_exec (
        .instruction    (s_instruction),
        .a_cur          (a_reg),
        .d_cur          (d_reg),
        .m_cur          (m_operand),
        .pc_cur         (pc_reg),
        .program_length (prog_len_reg),
        .res            (res)
    );

    assign a_next      = accept ? res.a_value : a_reg;
    assign raddr       = a_next[AW-1:0];
    assign wr_in_range = ({1'b0, res.mem_address} < 16'(DATA_DEPTH));

    always_comb begin
        if (clearing_reg) begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = '0;
        end else begin
            we    = accept && res.mem_write && wr_in_range;
            waddr = res.mem_address[AW-1:0];
            wdata = res.mem_data;
        end
    end

    hcc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DATA_DEPTH)
    ) u_dmem (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg           <= '0;
            d_reg           <= '0;
            pc_reg          <= '0;
            prog_len_reg    <= '0;
            clearing_reg    <= 1'b1;
            clr_cnt_reg     <= '0;
            rd_in_range_reg <= 1'b0;
            fwd_hit_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                prog_len_reg <= cfg_program_length;
            end
            if (clearing_reg) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DATA_DEPTH - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
            if (accept) begin
                a_reg  <= res.a_value;
                d_reg  <= res.d_value;
                pc_reg <= res.next_pc;
            end
            rd_in_range_reg <= ({1'b0, a_next[ADDR_W-1:0]} < 16'(DATA_DEPTH));
            fwd_hit_reg     <= we && (waddr == raddr);
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= wdata;
    end

    hcc_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_ready  (skid_ready),
        .in_data   (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_res)
    );

    assign m_next_pc     = out_res.next_pc;
    assign m_a_value     = out_res.a_value;
    assign m_d_value     = out_res.d_value;
    assign m_mem_write   = out_res.mem_write;
    assign m_mem_address = out_res.mem_address;
    assign m_mem_data    = out_res.mem_data;
    assign m_halted      = out_res.halted;
    assign m_bad_op      = out_res.bad_op;

endmodule
